### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the tokenizer modules. They expect i_clk and
// i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define QST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("qst assertion failed");

// Check that a condition never holds outside reset
`define QST_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("qst forbidden condition seen");

`endif

### src/qst_pkg.sv
// ----------------------------------------------------------------------------
// qst_pkg
// Shared constants and types of the quoted string tokenizer.
// ----------------------------------------------------------------------------
package qst_pkg;

    // Held whitespace store
    localparam int WS_HOLD = 16;
    localparam int HC_W    = $clog2(WS_HOLD + 1);
    localparam int HA_W    = (WS_HOLD > 1) ? $clog2(WS_HOLD) : 1;

    // Direct results per command (besides the whitespace flush)
    localparam int DIR_N   = 4;
    localparam int DIR_W   = $clog2(DIR_N + 1);

    // Result queue in the back end
    localparam int OQ_D    = 4;
    localparam int OQ_AW   = $clog2(OQ_D);
    localparam int OQ_CW   = $clog2(OQ_D + 1);

    // Result kinds
    localparam logic [2:0] K_CHAR   = 3'd0;
    localparam logic [2:0] K_END    = 3'd1;
    localparam logic [2:0] K_PUNCT  = 3'd2;
    localparam logic [2:0] K_STREAM = 3'd3;
    localparam logic [2:0] K_ERR    = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       fq;
    } t_res;

    // One command: flush held entries 0..flush_cnt-1, then n_dir results
    typedef struct packed {
        logic [HC_W-1:0]      flush_cnt;
        logic [DIR_W-1:0]     n_dir;
        t_res [DIR_N-1:0]     dir;
    } t_cmd;

    typedef struct packed {
        t_res res;
        logic run_last;
    } t_out;

endpackage

### src/qst_ram.sv
// ----------------------------------------------------------------------------
// qst_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module qst_ram #(
    parameter  int W  = 8,
    parameter  int D  = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [W-1:0]  i_wd,
    input  logic [AW-1:0] i_ra,
    output logic [W-1:0]  o_rd
);

    logic [W-1:0] r_mem [D];

    // Write, and read old contents on a clash
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end

endmodule

### src/qst_front.sv
// ----------------------------------------------------------------------------
// qst_front
// Accepts bytes, tracks quoting state, holds whitespace in the store and
// turns each item into a command for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qst_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [7:0]                i_ch,
    input  logic                      i_last_char,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_cmdq_full,
    input  logic                      i_retire,
    output logic                      o_cmd_push,
    output qst_pkg::t_cmd             o_cmd,
    output logic                      o_we,
    output logic [qst_pkg::HA_W-1:0]  o_wa,
    output logic [7:0]                o_wd
);
    import qst_pkg::*;

    localparam logic [7:0] C_LPAR  = 8'h28;
    localparam logic [7:0] C_RPAR  = 8'h29;
    localparam logic [7:0] C_LBRK  = 8'h5B;
    localparam logic [7:0] C_RBRK  = 8'h5D;
    localparam logic [7:0] C_COMMA = 8'h2C;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_BSL   = 8'h5C;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {C_LPAR, C_RPAR, C_LBRK, C_RBRK, C_COMMA, C_SEMI, C_LF, C_CR};
    endfunction

    logic            r_inq, n_inq;
    logic            r_bsh, n_bsh;
    logic            r_tko, n_tko;
    logic [HC_W-1:0] r_hc, n_hc;
    logic [1:0]      r_fout, n_fout;

    t_cmd             c_cmd;
    logic [DIR_W-1:0] c_nd;
    logic             c_we;
    logic [HA_W-1:0]  c_wa;
    logic             c_acc;

    // Stall on a full command queue, or in quotes while a flush still reads the store and new whitespace may land
    assign o_full = i_cmdq_full || (r_inq && (r_fout != 2'd0));
    assign c_acc  = i_push && !o_full;

    // Classify the item and build its command
    always_comb begin
        n_inq = r_inq;
        n_bsh = r_bsh;
        n_tko = r_tko;
        n_hc  = r_hc;
        c_cmd = '0;
        c_nd  = '0;
        c_we  = 1'b0;
        c_wa  = '0;
        if (r_inq) begin
            if (r_bsh) begin
                // escape: always yields a non-whitespace char first
                n_bsh = 1'b0;
                c_cmd.flush_cnt = n_hc;
                n_hc = '0;
                n_tko = 1'b1;
                if (i_ch == C_BSL || i_ch == C_QUOTE) begin
                    c_cmd.dir[c_nd[1:0]] = '{kind: K_CHAR, ch: i_ch, fq: 1'b1};
                    c_nd = c_nd + DIR_W'(1);
                end else begin
                    c_cmd.dir[c_nd[1:0]] = '{kind: K_CHAR, ch: C_BSL, fq: 1'b1};
                    c_nd = c_nd + DIR_W'(1);
                    if (!is_ws(i_ch)) begin
                        c_cmd.dir[c_nd[1:0]] = '{kind: K_CHAR, ch: i_ch, fq: 1'b1};
                        c_nd = c_nd + DIR_W'(1);
                    end else if (n_hc < HC_W'(WS_HOLD)) begin
                        c_we = 1'b1;
                        c_wa = n_hc[HA_W-1:0];
                        n_hc = n_hc + HC_W'(1);
                    end else begin
                        c_cmd.dir[c_nd[1:0]] = '{kind: K_ERR, ch: 8'h00, fq: 1'b1};
                        c_nd = c_nd + DIR_W'(1);
                    end
                end
            end else if (i_ch == C_QUOTE) begin
                // close quotes, drop held whitespace
                if (r_tko) begin
                    c_cmd.dir[c_nd[1:0]] = '{kind: K_END, ch: 8'h00, fq: 1'b1};
                    c_nd = c_nd + DIR_W'(1);
                end
                n_tko = 1'b0;
                n_hc  = '0;
                n_inq = 1'b0;
            end else if (i_ch == C_BSL) begin
                c_cmd.flush_cnt = n_hc;
                n_hc  = '0;
                n_bsh = 1'b1;
            end else if (!is_ws(i_ch)) begin
                c_cmd.flush_cnt = n_hc;
                n_hc = '0;
                c_cmd.dir[c_nd[1:0]] = '{kind: K_CHAR, ch: i_ch, fq: 1'b1};
                c_nd = c_nd + DIR_W'(1);
                n_tko = 1'b1;
            end else if (r_tko) begin
                // hold inner whitespace, or report overflow
                if (n_hc < HC_W'(WS_HOLD)) begin
                    c_we = 1'b1;
                    c_wa = n_hc[HA_W-1:0];
                    n_hc = n_hc + HC_W'(1);
                end else begin
                    c_cmd.dir[c_nd[1:0]] = '{kind: K_ERR, ch: 8'h00, fq: 1'b1};
                    c_nd = c_nd + DIR_W'(1);
                end
            end
        end else begin
            if (i_ch == C_QUOTE || is_punct(i_ch) || is_ws(i_ch)) begin
                if (r_tko) begin
                    c_cmd.dir[c_nd[1:0]] = '{kind: K_END, ch: 8'h00, fq: 1'b0};
                    c_nd = c_nd + DIR_W'(1);
                end
                n_tko = 1'b0;
                if (i_ch == C_QUOTE) begin
                    n_inq = 1'b1;
                end else if (is_punct(i_ch)) begin
                    c_cmd.dir[c_nd[1:0]] = '{kind: K_PUNCT, ch: i_ch, fq: 1'b0};
                    c_nd = c_nd + DIR_W'(1);
                end
            end else begin
                c_cmd.dir[c_nd[1:0]] = '{kind: K_CHAR, ch: i_ch, fq: 1'b0};
                c_nd = c_nd + DIR_W'(1);
                n_tko = 1'b1;
            end
        end
        // end of string: close up and return to reset state
        if (i_last_char) begin
            if (n_inq) begin
                c_cmd.dir[c_nd[1:0]] = '{kind: K_ERR, ch: 8'h00, fq: 1'b1};
                c_nd = c_nd + DIR_W'(1);
            end else if (n_tko) begin
                c_cmd.dir[c_nd[1:0]] = '{kind: K_END, ch: 8'h00, fq: 1'b0};
                c_nd = c_nd + DIR_W'(1);
            end
            c_cmd.dir[c_nd[1:0]] = '{kind: K_STREAM, ch: 8'h00, fq: 1'b0};
            c_nd  = c_nd + DIR_W'(1);
            n_inq = 1'b0;
            n_bsh = 1'b0;
            n_tko = 1'b0;
            n_hc  = '0;
        end
        c_cmd.n_dir = c_nd;
    end

    assign o_cmd      = c_cmd;
    assign o_cmd_push = c_acc && ((c_cmd.flush_cnt != '0) || (c_nd != '0));
    assign o_we       = c_acc && c_we;
    assign o_wa       = c_wa;
    assign o_wd       = i_ch;

    // Count flushes not yet fully read by the back end
    always_comb begin
        n_fout = r_fout;
        if (o_cmd_push && (c_cmd.flush_cnt != '0)) begin
            n_fout = n_fout + 2'd1;
        end
        if (i_retire) begin
            n_fout = n_fout - 2'd1;
        end
    end

    // Advance lexer state on an accepted item, and the flush count always
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inq  <= 1'b0;
            r_bsh  <= 1'b0;
            r_tko  <= 1'b0;
            r_hc   <= '0;
            r_fout <= 2'd0;
        end else begin
            if (c_acc) begin
                r_inq <= n_inq;
                r_bsh <= n_bsh;
                r_tko <= n_tko;
                r_hc  <= n_hc;
            end
            r_fout <= n_fout;
        end
    end

    `QST_ASSERT(a_bsh_state, r_bsh |-> (r_inq && (r_hc == '0)))
    `QST_NEVER(a_wr_during_flush, o_we && (r_fout != 2'd0))
    `QST_ASSERT(a_hc_bound, r_hc <= HC_W'(WS_HOLD))

endmodule

### src/qst_cmdq.sv
// ----------------------------------------------------------------------------
// qst_cmdq
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module qst_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qst_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output qst_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import qst_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       c_push, c_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign c_push  = i_push && !o_full;
    assign c_pop   = i_pop && !o_empty;
    assign o_cmd   = r_q[r_rp];

    // Store commands
    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_push) begin
                r_wp <= ~r_wp;
            end
            if (c_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, c_push} - {1'b0, c_pop};
        end
    end

endmodule

### src/qst_back.sv
// ----------------------------------------------------------------------------
// qst_back
// Carries out commands: reads the held whitespace out of the store, then
// emits the direct results, into a small result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qst_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  qst_pkg::t_cmd             i_cmd,
    input  logic                      i_cmdq_empty,
    output logic                      o_cmd_pop,
    output logic [qst_pkg::HA_W-1:0]  o_ra,
    input  logic [7:0]                i_rd,
    output logic                      o_retire,
    output qst_pkg::t_out             o_out,
    output logic                      o_empty,
    input  logic                      i_pop
);
    import qst_pkg::*;

    t_cmd             r_cmd;
    logic             r_busy;
    logic [HC_W-1:0]  r_idx;
    logic [DIR_W-1:0] r_di;
    logic             r_rdp;
    logic             r_rdlast;

    t_out             r_oq [OQ_D];
    logic [OQ_AW-1:0] r_wp, r_rp;
    logic [OQ_CW-1:0] r_cnt;

    logic c_flush_left, c_dir_left, c_issue, c_dpush, c_done, c_load;
    logic c_opush, c_opop, c_last_rd;
    t_out c_odata;

    // Sequence the current command
    assign c_flush_left = r_busy && (r_idx < r_cmd.flush_cnt);
    assign c_dir_left   = r_busy && !c_flush_left && (r_di < r_cmd.n_dir);
    assign c_issue      = c_flush_left && ((r_cnt + OQ_CW'(r_rdp)) < OQ_CW'(OQ_D));
    assign c_dpush      = c_dir_left && !r_rdp && (r_cnt < OQ_CW'(OQ_D));
    assign c_done       = r_busy && !c_flush_left && (r_di == r_cmd.n_dir);
    assign c_load       = (!r_busy || c_done) && !i_cmdq_empty;
    assign c_last_rd    = (r_idx + HC_W'(1)) == r_cmd.flush_cnt;

    assign o_cmd_pop = c_load;
    assign o_ra      = r_idx[HA_W-1:0];
    assign o_retire  = c_issue && c_last_rd;

    // Pick what enters the result queue: read data first, then direct results
    always_comb begin
        if (r_rdp) begin
            c_odata = '{res: '{kind: K_CHAR, ch: i_rd, fq: 1'b1}, run_last: r_rdlast};
        end else begin
            c_odata = '{res: r_cmd.dir[r_di[1:0]],
                        run_last: (r_di + DIR_W'(1)) == r_cmd.n_dir};
        end
    end

    assign c_opush = r_rdp || c_dpush;
    assign c_opop  = i_pop && (r_cnt != '0);
    assign o_empty = (r_cnt == '0);
    assign o_out   = r_oq[r_rp];

    // Load commands, hold payload
    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_cmd <= i_cmd;
        end
        if (c_issue) begin
            r_rdlast <= c_last_rd && (r_cmd.n_dir == '0);
        end
        if (c_opush) begin
            r_oq[r_wp] <= c_odata;
        end
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_di   <= '0;
            r_rdp  <= 1'b0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            r_rdp <= c_issue;
            if (c_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_di   <= '0;
            end else begin
                if (c_done) begin
                    r_busy <= 1'b0;
                end
                if (c_issue) begin
                    r_idx <= r_idx + HC_W'(1);
                end
                if (c_dpush) begin
                    r_di <= r_di + DIR_W'(1);
                end
            end
            if (c_opush) begin
                r_wp <= r_wp + OQ_AW'(1);
            end
            if (c_opop) begin
                r_rp <= r_rp + OQ_AW'(1);
            end
            r_cnt <= r_cnt + OQ_CW'(c_opush) - OQ_CW'(c_opop);
        end
    end

    `QST_ASSERT(a_oq_bound, r_cnt <= OQ_CW'(OQ_D))
    `QST_ASSERT(a_rd_source, r_rdp |-> $past(r_busy))
    `QST_NEVER(a_busy_overrun, r_busy && (r_di > r_cmd.n_dir))

endmodule

### src/quoted_string_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_string_tokenizer
// Path: an item's command passes the command queue and the back end's command
//   register, and a held whitespace flush is read from the store first.
// Flow: the back end loads a command as the last one finishes and writes one
//   result at a time; a two-entry command queue takes up bursts, and items
//   inside quotes wait while a flush is read from the store.
// Reset: synchronous, active low; control state clears, the store is not cleared.
// ----------------------------------------------------------------------------
module quoted_string_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_ch,
    input  logic       i_last_char,
    input  logic       push,
    output logic       full,
    output logic [2:0] o_kind,
    output logic [7:0] o_out_char,
    output logic       o_from_quotes,
    output logic       o_run_last,
    output logic       empty,
    input  logic       pop
);
    import qst_pkg::*;

    t_cmd            w_fcmd, w_bcmd;
    logic            w_fpush, w_cq_full, w_cq_empty, w_cq_pop, w_retire;
    logic            w_we;
    logic [HA_W-1:0] w_wa, w_ra;
    logic [7:0]      w_wd, w_rd;
    t_out            w_out;

    qst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ch        (i_ch),
        .i_last_char (i_last_char),
        .i_push      (push),
        .o_full      (full),
        .i_cmdq_full (w_cq_full),
        .i_retire    (w_retire),
        .o_cmd_push  (w_fpush),
        .o_cmd       (w_fcmd),
        .o_we        (w_we),
        .o_wa        (w_wa),
        .o_wd        (w_wd)
    );

    qst_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fpush),
        .i_cmd   (w_fcmd),
        .o_full  (w_cq_full),
        .i_pop   (w_cq_pop),
        .o_cmd   (w_bcmd),
        .o_empty (w_cq_empty)
    );

    qst_ram #(
        .W (8),
        .D (WS_HOLD)
    ) u_ws_ram (
        .i_clk (i_clk),
        .i_we  (w_we),
        .i_wa  (w_wa),
        .i_wd  (w_wd),
        .i_ra  (w_ra),
        .o_rd  (w_rd)
    );

    qst_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_bcmd),
        .i_cmdq_empty (w_cq_empty),
        .o_cmd_pop    (w_cq_pop),
        .o_ra         (w_ra),
        .i_rd         (w_rd),
        .o_retire     (w_retire),
        .o_out        (w_out),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    // Present the oldest result
    assign o_kind        = w_out.res.kind;
    assign o_out_char    = w_out.res.ch;
    assign o_from_quotes = w_out.res.fq;
    assign o_run_last    = w_out.run_last;

endmodule

### test/qst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qst_checker
// Watches both queue sides of the tokenizer. Every accepted input byte is run
// through a cycle-free model of the lexer: quote state, escapes, the held
// whitespace store and the stream end. The model queues the results that the
// byte should cause. Each result popped from the block is compared field by
// field with the oldest queued one. A failure count and the number of results
// still owed are handed to the top.
// ----------------------------------------------------------------------------
module qst_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_ch,
    input  logic       i_last_char,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_out_char,
    input  logic       i_from_quotes,
    input  logic       i_run_last,
    input  logic       i_empty,
    input  logic       i_pop,
    output int         o_fail_count,
    output int         o_pending
);
    import qst_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam int         MAX_LINES = 20;

    // Results owed by the block, oldest first
    t_out       token_q[$];
    t_out       byte_out[$];

    // Lexer state
    logic       in_quote;
    logic       esc_pending;
    logic       word_open;
    logic [7:0] ws_store [WS_HOLD];
    int         ws_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        in_quote     = 1'b0;
        esc_pending  = 1'b0;
        word_open    = 1'b0;
        ws_count     = 0;
    end

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D ||
               c == 8'h2C || c == 8'h3B || c == 8'h0A || c == 8'h0D;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        if (o_fail_count < MAX_LINES)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
        o_fail_count++;
    endtask

    task automatic add_result(input logic [2:0] k, input logic [7:0] c, input logic fq);
        t_out r;
        r.res.kind = k;
        r.res.ch   = c;
        r.res.fq   = fq;
        r.run_last = 1'b0;
        byte_out = {byte_out, r};
    endtask

    // Release held whitespace into the quoted token
    task automatic release_spaces();
        for (int k = 0; k < ws_count; k++)
            add_result(K_CHAR, ws_store[k], 1'b1);
        ws_count = 0;
    endtask

    // One character of quoted text, after escape handling
    task automatic quoted_byte(input logic [7:0] c);
        if (!is_space(c)) begin
            release_spaces();
            add_result(K_CHAR, c, 1'b1);
            word_open = 1'b1;
        end else if (word_open) begin
            if (ws_count < WS_HOLD) begin
                ws_store[ws_count] = c;
                ws_count++;
            end else begin
                add_result(K_ERR, 8'h00, 1'b1);
            end
        end
    endtask

    task automatic close_plain();
        if (word_open)
            add_result(K_END, 8'h00, 1'b0);
        word_open = 1'b0;
    endtask

    // Work out every result that one input byte causes
    task automatic tokenize_byte(input logic [7:0] c, input logic last);
        t_out r;
        byte_out.delete();
        if (in_quote) begin
            if (esc_pending) begin
                esc_pending = 1'b0;
                if (c == CH_BSLASH || c == CH_QUOTE) begin
                    quoted_byte(c);
                end else begin
                    quoted_byte(CH_BSLASH);
                    quoted_byte(c);
                end
            end else if (c == CH_QUOTE) begin
                if (word_open)
                    add_result(K_END, 8'h00, 1'b1);
                word_open = 1'b0;
                ws_count  = 0;
                in_quote  = 1'b0;
            end else if (c == CH_BSLASH) begin
                release_spaces();
                esc_pending = 1'b1;
            end else begin
                quoted_byte(c);
            end
        end else begin
            if (c == CH_QUOTE) begin
                close_plain();
                in_quote = 1'b1;
            end else if (is_punct(c)) begin
                close_plain();
                add_result(K_PUNCT, c, 1'b0);
            end else if (is_space(c)) begin
                close_plain();
            end else begin
                add_result(K_CHAR, c, 1'b0);
                word_open = 1'b1;
            end
        end

        // Finish the stream and return to the idle state
        if (last) begin
            if (in_quote)
                add_result(K_ERR, 8'h00, 1'b1);
            else
                close_plain();
            add_result(K_STREAM, 8'h00, 1'b0);
            in_quote    = 1'b0;
            esc_pending = 1'b0;
            word_open   = 1'b0;
            ws_count    = 0;
        end

        foreach (byte_out[k]) begin
            r          = byte_out[k];
            r.run_last = (k == byte_out.size() - 1);
            token_q    = {token_q, r};
        end
    endtask

    // Predict on accepted input items, then compare accepted results
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            token_q.delete();
            in_quote    = 1'b0;
            esc_pending = 1'b0;
            word_open   = 1'b0;
            ws_count    = 0;
        end else begin
            if (i_push && !i_full)
                tokenize_byte(i_ch, i_last_char);
            if (i_pop && !i_empty) begin
                if (token_q.size() == 0) begin
                    report_mismatch("unexpected result, kind", 8'h00, {5'd0, i_kind});
                end else begin
                    want = token_q.pop_front();
                    if (i_kind !== want.res.kind)
                        report_mismatch("kind", {5'd0, want.res.kind}, {5'd0, i_kind});
                    if (i_out_char !== want.res.ch)
                        report_mismatch("out_char", want.res.ch, i_out_char);
                    if (i_from_quotes !== want.res.fq)
                        report_mismatch("from_quotes", {7'd0, want.res.fq},
                                        {7'd0, i_from_quotes});
                    if (i_run_last !== want.run_last)
                        report_mismatch("run_last", {7'd0, want.run_last},
                                        {7'd0, i_run_last});
                end
            end
        end
        o_pending = token_q.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the tokenizer with a short directed run of punctuation, whitespace,
// quoted text, escapes and unterminated quotes, then with random command
// lines built from words, punctuation, whitespace and quoted strings, plus a
// share of raw noise. The sender works in bursts and the receiver stalls on a
// changing pattern. Checking is done by qst_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import qst_pkg::*;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam int         ITEM_COUNT = 360;
    localparam int         IDLE_LIMIT = 2000;
    localparam int         DRAIN_WAIT = 20;

    logic       i_clk;
    logic       i_rst_n;
    logic [7:0] i_ch;
    logic       i_last_char;
    logic       push;
    logic       full;
    logic [2:0] o_kind;
    logic [7:0] o_out_char;
    logic       o_from_quotes;
    logic       o_run_last;
    logic       empty;
    logic       pop;

    int         fail_count;
    int         pending;
    int         burst_left;
    int         items_sent;
    int         idle_cycles;
    int         pop_mode;
    int         pop_phase;
    int         mode_left;

    quoted_string_tokenizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ch          (i_ch),
        .i_last_char   (i_last_char),
        .push          (push),
        .full          (full),
        .o_kind        (o_kind),
        .o_out_char    (o_out_char),
        .o_from_quotes (o_from_quotes),
        .o_run_last    (o_run_last),
        .empty         (empty),
        .pop           (pop)
    );

    qst_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ch          (i_ch),
        .i_last_char   (i_last_char),
        .i_push        (push),
        .i_full        (full),
        .i_kind        (o_kind),
        .i_out_char    (o_out_char),
        .i_from_quotes (o_from_quotes),
        .i_run_last    (o_run_last),
        .i_empty       (empty),
        .i_pop         (pop),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Send one byte; called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        push        <= 1'b1;
        i_ch        <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // Hold the sender until every owed result has come out
    task automatic drain_results();
        push <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        burst_left = 0;
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 5))
            0:       return 8'h09;
            1:       return 8'h0A;
            2:       return 8'h0B;
            3:       return 8'h0C;
            4:       return 8'h0D;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 7))
            0:       return 8'h28;
            1:       return 8'h29;
            2:       return 8'h5B;
            3:       return 8'h5D;
            4:       return 8'h2C;
            5:       return 8'h3B;
            6:       return 8'h0A;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 7))
            0:       return 8'($urandom_range(8'h80, 8'hFF));
            1:       return 8'($urandom_range(8'h21, 8'h7E));
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    // Build one command line of random content and send it, last byte flagged
    task automatic send_line();
        logic [7:0] text[$];
        int         pieces;
        int         len;
        int         sub;
        pieces = $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 12);
            repeat (len) text = {text, 8'($urandom_range(0, 255))};
        end else begin
            repeat (pieces) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        len = $urandom_range(1, 6);
                        repeat (len) text = {text, pick_letter()};
                    end
                    3: text = {text, pick_punct()};
                    4, 5: begin
                        len = $urandom_range(1, 3);
                        repeat (len) text = {text, pick_space()};
                    end
                    default: begin
                        text = {text, CH_QUOTE};
                        len = $urandom_range(0, 5);
                        repeat (len) begin
                            sub = $urandom_range(0, 7);
                            case (sub)
                                0, 1, 2: text = {text, pick_letter()};
                                3: repeat ($urandom_range(1, 3)) text = {text, pick_space()};
                                4: begin
                                    text = {text, CH_BSLASH};
                                    text = {text, CH_BSLASH};
                                end
                                5: begin
                                    text = {text, CH_BSLASH};
                                    text = {text, CH_QUOTE};
                                end
                                6: begin
                                    text = {text, CH_BSLASH};
                                    text = {text, 8'($urandom_range(0, 255))};
                                end
                                default: begin
                                    // Long runs now and then overflow the store
                                    if ($urandom_range(0, 2) == 0)
                                        repeat ($urandom_range(14, 20))
                                            text = {text, pick_space()};
                                    else
                                        repeat ($urandom_range(4, 8))
                                            text = {text, pick_space()};
                                end
                            endcase
                        end
                        if ($urandom_range(0, 9) != 0)
                            text = {text, CH_QUOTE};
                    end
                endcase
            end
        end
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    // Stimulus and verdict
    initial begin
        logic pressure_done;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_ch          = 8'h00;
        i_last_char   = 1'b0;
        burst_left    = 0;
        items_sent    = 0;
        pressure_done = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Extreme bytes, every punctuation mark, open token closed at stream end
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(8'h28, 1'b0);
        send_byte(8'h29, 1'b0);
        send_byte(8'h5B, 1'b0);
        send_byte(8'h5D, 1'b0);
        send_byte(8'h2C, 1'b0);
        send_byte(8'h3B, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte("t", 1'b1);

        // Quoted text: leading space, held space released by a backslash,
        // escapes, trailing space dropped, empty quotes, unterminated quote
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte("a", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte("x", 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte("z", 1'b1);
        drain_results();

        // Random command lines, with one full drain half way
        while (items_sent < ITEM_COUNT) begin
            send_line();
            if (!pressure_done && items_sent > ITEM_COUNT / 2) begin
                drain_results();
                pressure_done = 1'b1;
            end
        end
        push <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("quoted_string_tokenizer test passed");
        else
            $display("quoted_string_tokenizer test failed");
        $finish;
    end

    // Receiver: stall pattern changes mode after a run of random length
    initial begin
        pop       = 1'b0;
        pop_mode  = 0;
        pop_phase = 0;
        mode_left = 0;
    end

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            pop_mode  = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        pop_phase = (pop_phase + 1) % 5;
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= (pop_phase >= 3);
            default: pop <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Watchdog: end the run when nothing moves for too long
    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("quoted_string_tokenizer test failed");
            $finish;
        end
    end

endmodule

### quoted_string_tokenizer.f
+incdir+src
src/qst_pkg.sv
src/qst_ram.sv
src/qst_front.sv
src/qst_cmdq.sv
src/qst_back.sv
src/quoted_string_tokenizer.sv
test/qst_checker.sv
test/tb_top.sv
